@@ rtl/recent_event_dedup_filter_assert.svh @@
// Assertion macros for the recent event duplicate filter
`ifndef RECENT_EVENT_DEDUP_FILTER_ASSERT_SVH
`define RECENT_EVENT_DEDUP_FILTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define REDF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("recent_event_dedup_filter: assertion failed");

// next-cycle implication, checked out of reset
`define REDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("recent_event_dedup_filter: assertion failed");

`endif

@@ rtl/redf_pkg.sv @@
// Package: depths, widths and codes of the recent event duplicate filter
`timescale 1ns / 1ps

package redf_pkg;

    localparam int KEY_DEPTH  = 128;
    localparam int MARK_DEPTH = 32;

    localparam int KEY_AW   = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int MARK_AW  = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
    localparam int SCAN_MAX = (KEY_DEPTH > MARK_DEPTH) ? KEY_DEPTH : MARK_DEPTH;
    localparam int SCAN_CW  = $clog2(SCAN_MAX + 1);

    localparam int KEY_W    = 64;
    localparam int ID_W     = 32;
    localparam int INDEX_W  = 16;
    localparam int TIME_W   = 32;
    localparam int REASON_W = 2;

    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;
    localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd2000;

    typedef logic [REASON_W-1:0] reason_t;

    localparam reason_t REASON_FRESH  = 2'd0;
    localparam reason_t REASON_KEY    = 2'd1;
    localparam reason_t REASON_LETHAL = 2'd2;

    localparam logic REG_WINDOW = 1'b0;

endpackage

@@ rtl/recent_event_dedup_filter.sv @@
// Top level: duplicate filter over FIFO windows of recent event keys and lethal marks
`timescale 1ns / 1ps

// Each item is checked in two scans by one shared compare unit under a small
// sequencer. The key scan reads the key memory one entry a cycle, with a registered
// read port; a fresh key is then written to the ring. A fresh lethal item then
// scans the mark memory. A key match ends the scan at once. s_ready is low from
// acceptance until the result item is taken. No clearing pass is needed: valid bits
// are cleared by reset. lethal_window_ms (byte address 0, reset 2000) is to be
// written by the user only while the block is idle; the block does not enforce it.

`include "recent_event_dedup_filter_assert.svh"

module recent_event_dedup_filter
    import redf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CFG_AW-1:0]   paddr,
    input  logic [CFG_DW-1:0]   pwdata,
    output logic [CFG_DW-1:0]   prdata,
    output logic                pready,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ID_W-1:0]     s_event_id,
    input  logic [INDEX_W-1:0]  s_attacker_index,
    input  logic [INDEX_W-1:0]  s_defender_index,
    input  logic                s_is_lethal,
    input  logic [TIME_W-1:0]   s_now_ms,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_is_duplicate,
    output logic [REASON_W-1:0] m_dup_reason
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_KSCAN = 2'd1;
    localparam logic [1:0] ST_MSCAN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [TIME_W-1:0]      window_reg;

    logic [KEY_W-1:0]       key_reg;
    logic [INDEX_W-1:0]     def_reg;
    logic [TIME_W-1:0]      now_reg;
    logic                   lethal_reg;

    logic [SCAN_CW-1:0]     rd_idx_reg, rd_idx_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [SCAN_CW-1:0]     cmp_idx_reg, cmp_idx_next;
    reason_t                reason_reg, reason_next;

    logic [KEY_DEPTH-1:0]   key_valid_reg, key_valid_next;
    logic [KEY_AW-1:0]      key_slot_reg, key_slot_next;
    logic [MARK_DEPTH-1:0]  mark_valid_reg, mark_valid_next;
    logic [MARK_AW-1:0]     mark_slot_reg, mark_slot_next;

    logic [KEY_W-1:0]       key_mem [KEY_DEPTH];
    logic [INDEX_W-1:0]     mark_def_mem [MARK_DEPTH];
    logic [TIME_W-1:0]      mark_time_mem [MARK_DEPTH];
    logic [KEY_W-1:0]       key_rdata_reg;
    logic [INDEX_W-1:0]     mark_rdef_reg;
    logic [TIME_W-1:0]      mark_rtime_reg;

    logic                   key_wr, mark_wr;
    logic                   key_hit, mark_hit;
    logic                   key_last, mark_last;
    logic [TIME_W-1:0]      mark_age;
    logic [SCAN_CW-1:0]     scan_limit;
    logic                   cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[CFG_AW-1] == REG_WINDOW);
    assign prdata = (paddr[CFG_AW-1] == REG_WINDOW) ? window_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (cfg_wr) begin
            window_reg <= pwdata;
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (key_wr) begin
            key_mem[key_slot_reg] <= key_reg;
        end
        key_rdata_reg <= key_mem[rd_idx_reg[KEY_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (mark_wr) begin
            mark_def_mem[mark_slot_reg]  <= def_reg;
            mark_time_mem[mark_slot_reg] <= now_reg;
        end
        mark_rdef_reg  <= mark_def_mem[rd_idx_reg[MARK_AW-1:0]];
        mark_rtime_reg <= mark_time_mem[rd_idx_reg[MARK_AW-1:0]];
    end

    // shared compare unit
    assign mark_age  = now_reg - mark_rtime_reg;
    assign key_hit   = cmp_vld_reg && key_valid_reg[cmp_idx_reg[KEY_AW-1:0]]
                       && (key_rdata_reg == key_reg);
    assign mark_hit  = cmp_vld_reg && mark_valid_reg[cmp_idx_reg[MARK_AW-1:0]]
                       && (mark_rdef_reg == def_reg) && (mark_age < window_reg);
    assign key_last  = cmp_vld_reg && (cmp_idx_reg == SCAN_CW'(KEY_DEPTH - 1));
    assign mark_last = cmp_vld_reg && (cmp_idx_reg == SCAN_CW'(MARK_DEPTH - 1));
    assign scan_limit = (state_reg == ST_MSCAN) ? SCAN_CW'(MARK_DEPTH)
                                                : SCAN_CW'(KEY_DEPTH);

    assign key_wr  = (state_reg == ST_KSCAN) && !key_hit && key_last;
    assign mark_wr = (state_reg == ST_MSCAN) && !mark_hit && mark_last;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = rd_idx_reg;
        reason_next     = reason_reg;
        key_valid_next  = key_valid_reg;
        key_slot_next   = key_slot_reg;
        mark_valid_next = mark_valid_reg;
        mark_slot_next  = mark_slot_reg;

        if (rd_idx_reg < scan_limit) begin
            cmp_vld_next = 1'b1;
            rd_idx_next  = rd_idx_reg + SCAN_CW'(1);
        end

        unique case (state_reg)
            ST_IDLE: begin
                cmp_vld_next = 1'b0;
                rd_idx_next  = '0;
                if (s_valid) begin
                    state_next = ST_KSCAN;
                end
            end
            ST_KSCAN: begin
                if (key_hit) begin
                    reason_next = REASON_KEY;
                    state_next  = ST_OUT;
                end else if (key_last) begin
                    key_valid_next[key_slot_reg] = 1'b1;
                    key_slot_next = (key_slot_reg == KEY_AW'(KEY_DEPTH - 1))
                                    ? '0 : key_slot_reg + KEY_AW'(1);
                    rd_idx_next  = '0;
                    cmp_vld_next = 1'b0;
                    reason_next  = REASON_FRESH;
                    state_next   = lethal_reg ? ST_MSCAN : ST_OUT;
                end
            end
            ST_MSCAN: begin
                if (mark_hit) begin
                    reason_next = REASON_LETHAL;
                    state_next  = ST_OUT;
                end else if (mark_last) begin
                    mark_valid_next[mark_slot_reg] = 1'b1;
                    mark_slot_next = (mark_slot_reg == MARK_AW'(MARK_DEPTH - 1))
                                     ? '0 : mark_slot_reg + MARK_AW'(1);
                    reason_next = REASON_FRESH;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                cmp_vld_next = 1'b0;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rd_idx_reg     <= '0;
            cmp_vld_reg    <= 1'b0;
            key_valid_reg  <= '0;
            key_slot_reg   <= '0;
            mark_valid_reg <= '0;
            mark_slot_reg  <= '0;
        end else begin
            state_reg      <= state_next;
            rd_idx_reg     <= rd_idx_next;
            cmp_vld_reg    <= cmp_vld_next;
            key_valid_reg  <= key_valid_next;
            key_slot_reg   <= key_slot_next;
            mark_valid_reg <= mark_valid_next;
            mark_slot_reg  <= mark_slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= cmp_idx_next;
        reason_reg  <= reason_next;
        if (s_valid && s_ready) begin
            key_reg    <= {s_event_id, s_attacker_index, s_defender_index};
            def_reg    <= s_defender_index;
            now_reg    <= s_now_ms;
            lethal_reg <= s_is_lethal;
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = (state_reg == ST_OUT);
    assign m_dup_reason   = reason_reg;
    assign m_is_duplicate = (reason_reg != REASON_FRESH);

    `REDF_ASSERT_NOW(a_one_side, m_valid, !s_ready)
    `REDF_ASSERT_NEXT(a_accept_busy, s_valid && s_ready, !s_ready && !m_valid)
    `REDF_ASSERT_NOW(a_mark_after_fresh_key, mark_wr, lethal_reg && (reason_reg == REASON_FRESH))

endmodule

@@ bench/recent_event_dedup_filter_tb.sv @@
`timescale 1ns / 1ps
// Testbench: directed and random events checked against a behavioural duplicate predictor

module recent_event_dedup_filter_tb;
    import redf_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int HISTORY_DEPTH = 400;
    localparam logic [CFG_AW-1:0] WINDOW_ADDR = CFG_AW'(4 * REG_WINDOW);
    localparam logic [CFG_AW-1:0] SPARE_ADDR  = CFG_AW'(4 * (REG_WINDOW + 1));

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [INDEX_W-1:0] attacker;
        logic [INDEX_W-1:0] defender;
        logic               lethal;
        logic [TIME_W-1:0]  stamp;
    } hit_item_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [CFG_AW-1:0]   paddr = '0;
    logic [CFG_DW-1:0]   pwdata = '0;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [ID_W-1:0]     s_event_id = '0;
    logic [INDEX_W-1:0]  s_attacker_index = '0;
    logic [INDEX_W-1:0]  s_defender_index = '0;
    logic                s_is_lethal = 1'b0;
    logic [TIME_W-1:0]   s_now_ms = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_is_duplicate;
    logic [REASON_W-1:0] m_dup_reason;

    recent_event_dedup_filter dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_event_id       (s_event_id),
        .s_attacker_index (s_attacker_index),
        .s_defender_index (s_defender_index),
        .s_is_lethal      (s_is_lethal),
        .s_now_ms         (s_now_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_is_duplicate   (m_is_duplicate),
        .m_dup_reason     (m_dup_reason)
    );

    // predictor state
    logic [KEY_W-1:0]   seen_keys [KEY_DEPTH];
    bit                 seen_key_valid [KEY_DEPTH];
    int                 key_slot = 0;
    logic [INDEX_W-1:0] kill_defender [MARK_DEPTH];
    logic [TIME_W-1:0]  kill_time [MARK_DEPTH];
    bit                 kill_valid [MARK_DEPTH];
    int                 kill_slot = 0;
    logic [TIME_W-1:0]  window_ms = WINDOW_RESET;

    hit_item_t          hits_to_send [$];
    hit_item_t          recent_hits [$];
    reason_t            pending_verdicts [$];
    logic [INDEX_W-1:0] defender_pool [8];
    logic [TIME_W-1:0]  clock_ms = '0;
    int unsigned        step_cap = 500;
    bit                 calm = 1'b0;
    bit                 hit_taken = 1'b0;
    int                 send_gap = 0;
    int                 result_stall = 0;
    int                 mismatches = 0;
    longint             cycle_count = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("recent_event_dedup_filter verification failed");
            $finish;
        end
    end

    function automatic reason_t predict_reason(hit_item_t h);
        logic [KEY_W-1:0] key;
        key = {h.id, h.attacker, h.defender};
        for (int i = 0; i < KEY_DEPTH; i++) begin
            if (seen_key_valid[i] && seen_keys[i] == key) return REASON_KEY;
        end
        seen_keys[key_slot] = key;
        seen_key_valid[key_slot] = 1'b1;
        key_slot = (key_slot + 1) % KEY_DEPTH;
        if (!h.lethal) return REASON_FRESH;
        for (int i = 0; i < MARK_DEPTH; i++) begin
            if (kill_valid[i] && kill_defender[i] == h.defender &&
                    TIME_W'(h.stamp - kill_time[i]) < window_ms) return REASON_LETHAL;
        end
        kill_defender[kill_slot] = h.defender;
        kill_time[kill_slot] = h.stamp;
        kill_valid[kill_slot] = 1'b1;
        kill_slot = (kill_slot + 1) % MARK_DEPTH;
        return REASON_FRESH;
    endfunction

    function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        if (mismatches < 10) $display("mismatch on %s: expected %0h, got %0h", what, want, got);
        mismatches++;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver: hold each item until taken, then idle for a random gap
    always @(negedge aclk) begin
        hit_item_t next_hit;
        if (aresetn) begin
            if (s_valid && hit_taken) send_gap = pick_gap();
            if (!s_valid || hit_taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (hits_to_send.size() != 0) begin
                    next_hit = hits_to_send[0];
                    hits_to_send.delete(0);
                    s_event_id       <= next_hit.id;
                    s_attacker_index <= next_hit.attacker;
                    s_defender_index <= next_hit.defender;
                    s_is_lethal      <= next_hit.lethal;
                    s_now_ms         <= next_hit.stamp;
                    s_valid          <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (result_stall > 0) begin
                result_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) result_stall = pick_gap();
            end
        end
    end

    // monitor: predict on each accepted item, check each accepted result
    always @(posedge aclk) begin
        reason_t want;
        hit_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            pending_verdicts.insert(pending_verdicts.size(),
                                    predict_reason({s_event_id, s_attacker_index,
                                                    s_defender_index, s_is_lethal,
                                                    s_now_ms}));
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                flag_mismatch("result with none pending", 32'(0), 32'(m_dup_reason));
            end else begin
                want = pending_verdicts[0];
                pending_verdicts.delete(0);
                if (m_dup_reason !== want)
                    flag_mismatch("dup_reason", 32'(want), 32'(m_dup_reason));
                if (m_is_duplicate !== (want != REASON_FRESH))
                    flag_mismatch("is_duplicate", 32'(want != REASON_FRESH),
                                  32'(m_is_duplicate));
            end
        end
    end

    task automatic push_hit(logic [ID_W-1:0] id, logic [INDEX_W-1:0] attacker,
                            logic [INDEX_W-1:0] defender, logic lethal, logic [TIME_W-1:0] stamp);
        hit_item_t h;
        h = {id, attacker, defender, lethal, stamp};
        hits_to_send.insert(hits_to_send.size(), h);
        recent_hits.insert(recent_hits.size(), h);
        if (recent_hits.size() > HISTORY_DEPTH) recent_hits.delete(0);
    endtask

    task automatic make_random_hit();
        hit_item_t h;
        int pick;
        int span;
        int back;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 3) clock_ms = $urandom();
        else clock_ms += $urandom_range(0, step_cap);
        h.id = $urandom();
        h.attacker = INDEX_W'($urandom_range(0, 16'hFFFF));
        h.defender = defender_pool[$urandom_range(0, 7)];
        h.lethal = 1'b1;
        h.stamp = clock_ms;
        if (pick < 25 && recent_hits.size() != 0) begin
            span = recent_hits.size() < 100 ? recent_hits.size() : 100;
            if ($urandom_range(0, 3) != 0) back = $urandom_range(0, span - 1);
            else back = $urandom_range(0, recent_hits.size() - 1);
            h = recent_hits[recent_hits.size() - 1 - back];
            h.lethal = 1'($urandom_range(0, 1));
            h.stamp = clock_ms;
        end else if (pick < 65) begin
            if ($urandom_range(0, 9) == 0) h.stamp = clock_ms - $urandom_range(1, 3);
        end else if (pick < 75) begin
            h.defender = INDEX_W'($urandom_range(0, 16'hFFFF));
            h.lethal = 1'($urandom_range(0, 1));
            h.stamp = $urandom();
        end else begin
            h.lethal = 1'b0;
        end
        push_hit(h.id, h.attacker, h.defender, h.lethal, h.stamp);
    endtask

    task automatic wait_until_idle();
        while (hits_to_send.size() != 0 || s_valid || pending_verdicts.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) make_random_hit();
        wait_until_idle();
    endtask

    task automatic apb_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if ((addr >> 2) == REG_WINDOW) window_ms = data;
    endtask

    task automatic apb_check_window();
        logic [CFG_DW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= WINDOW_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== window_ms) flag_mismatch("lethal_window_ms readback", window_ms, got);
    endtask

    task automatic set_window(logic [TIME_W-1:0] value, int unsigned cap);
        apb_write(WINDOW_ADDR, value);
        apb_check_window();
        step_cap = cap;
    endtask

    initial begin
        logic [TIME_W-1:0] w;
        defender_pool[0] = '0;
        defender_pool[1] = '1;
        for (int i = 2; i < 8; i++) defender_pool[i] = INDEX_W'($urandom_range(0, 16'hFFFF));
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        apb_check_window();
        push_hit(32'h0, 16'h0, 16'h0, 1'b0, 32'h0);
        push_hit(32'h0, 16'h0, 16'h0, 1'b0, 32'h0);
        push_hit(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        push_hit(32'hFFFF_FFFE, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0);
        push_hit(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        push_hit(32'd1, 16'h0, 16'hFFFF, 1'b0, 32'd5);
        push_hit(32'd2, 16'h0, 16'hFFFF, 1'b1, 32'd1998);
        push_hit(32'd3, 16'h0, 16'hFFFF, 1'b1, 32'd1999);
        push_hit(32'd4, 16'h5, 16'h1234, 1'b1, 32'd100);
        push_hit(32'd5, 16'h5, 16'h1234, 1'b1, 32'd99);
        push_hit(32'd6, 16'hA5A5, 16'h5A5A, 1'b1, 32'h8000_0000);
        wait_until_idle();

        apb_write(SPARE_ADDR, $urandom());
        apb_check_window();
        step_cap = 501;
        run_random(500);

        set_window(32'd0, 50);
        push_hit(32'd7, 16'h1, 16'h1234, 1'b1, 32'd100);
        push_hit(32'd8, 16'h1, 16'h1234, 1'b1, 32'd100);
        run_random(300);

        set_window(32'hFFFF_FFFF, 200000);
        push_hit(32'd9, 16'h2, 16'h4321, 1'b1, 32'd1000);
        push_hit(32'd10, 16'h2, 16'h4321, 1'b1, 32'd999);
        push_hit(32'd11, 16'h2, 16'h4321, 1'b1, 32'd1005);
        run_random(300);

        calm = 1'b1;
        set_window(32'd1, 1);
        push_hit(32'd12, 16'h3, 16'h0F0F, 1'b1, 32'd500);
        push_hit(32'd13, 16'h3, 16'h0F0F, 1'b1, 32'd500);
        push_hit(32'd14, 16'h3, 16'h0F0F, 1'b1, 32'd501);
        run_random(300);
        calm = 1'b0;

        w = $urandom_range(2, 100000);
        set_window(w, w / 4 + 1);
        run_random(300);

        set_window($urandom(), 200000);
        run_random(200);

        set_window(WINDOW_RESET, 501);
        run_random(100);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("recent_event_dedup_filter verification clean");
        end else begin
            $display("recent_event_dedup_filter verification failed");
        end
        $finish;
    end

endmodule
